// ----- hw/rtl/ffha_pkg.sv -----
package ffha_pkg;

    localparam int HEAP_BYTES_DEF      = 65536;
    localparam int MAX_FREE_DEF        = 16;
    localparam int HEADER_BYTES_DEF    = 8;
    localparam int MIN_BLOCK_BYTES_DEF = 24;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_ZERO    = 2'd1;
    localparam t_status ST_NOMEM   = 2'd2;
    localparam t_status ST_TBLFULL = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// First-fit heap allocator with an address-sorted free table and coalescing.
// Command channel: a beat is taken at a clock edge with i_start high and
// o_busy low. i_op selects allocate (i_req_bytes) or free (i_user_addr).
// Exactly one result beat follows per command: o_done is high for one cycle
// with o_status, o_grant_addr, o_grant_bytes and o_top_released. The
// receiver cannot stall; the result is simply gone after that cycle.
// o_busy stays high from the accept until the o_done cycle ends.
// Each command runs on one small sequencer that walks the free table one
// entry per cycle. Allocate scans the entries in address order for the
// first that fits, else grows the break, then splits or removes that entry
// (removal shifts the later entries down) and writes the block size. Free
// reads the block size, scans for its place, then merges or inserts (an
// insert shifts entries up). Zero-size and early-rejected frees go straight
// to the result. A new beat can be taken the cycle after o_done.
// The block-size store is a single memory with a registered read.
// Config channel: i_cfg_valid/o_cfg_ready write align_log2; write only
// while idle. Reset (synchronous, i_rst_n low) empties the free table,
// zeroes the break and sets align_log2 to 3; the memories are not cleared.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES      = ffha_pkg::HEAP_BYTES_DEF,
    parameter int MAX_FREE        = ffha_pkg::MAX_FREE_DEF,
    parameter int HEADER_BYTES    = ffha_pkg::HEADER_BYTES_DEF,
    parameter int MIN_BLOCK_BYTES = ffha_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_op,
    input  logic [16:0] i_req_bytes,
    input  logic [15:0] i_user_addr,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_grant_addr,
    output logic [16:0] o_grant_bytes,
    output logic        o_top_released,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);

    localparam int AW0 = $clog2(HEAP_BYTES) + 2;
    localparam int AW  = (AW0 > 19) ? AW0 : 19;
    localparam int DW  = $clog2(HEAP_BYTES) + 1;
    localparam int SD  = HEAP_BYTES / 8;
    localparam int SW  = $clog2(SD);
    localparam int IW  = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
    localparam int CW  = $clog2(MAX_FREE + 1);

    localparam logic [AW-1:0] HEAP = AW'(HEAP_BYTES);
    localparam logic [AW-1:0] HDR  = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] MINB = AW'(MIN_BLOCK_BYTES);
    localparam logic [CW-1:0] MAXF = CW'(MAX_FREE);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ASCAN = 4'd1;
    localparam logic [3:0] S_AWR   = 4'd2;
    localparam logic [3:0] S_FWAIT = 4'd3;
    localparam logic [3:0] S_FSIZE = 4'd4;
    localparam logic [3:0] S_FSCAN = 4'd5;
    localparam logic [3:0] S_FCHK  = 4'd6;
    localparam logic [3:0] S_SHDN  = 4'd7;
    localparam logic [3:0] S_SHUP  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]    r_state;
    logic [2:0]    r_align;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_p;
    logic [AW-1:0] r_brk;
    logic          r_op;
    logic [AW-1:0] r_blk;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_fstart;
    logic [AW-1:0] r_fsize;
    logic [AW-1:0] r_fend;
    logic [AW-1:0] r_pend;
    logic [AW-1:0] r_psize;
    logic          r_left;
    logic [SW-1:0] r_sidx;
    logic [DW-1:0] r_rdata;
    ffha_pkg::t_status r_status;
    logic [15:0]   r_gaddr;
    logic [16:0]   r_gbytes;
    logic          r_top;

    logic [AW-1:0] r_fst [MAX_FREE];
    logic [AW-1:0] r_fsz [MAX_FREE];
    logic [DW-1:0] r_store [SD];

    logic [AW-1:0] amask;
    logic [AW-1:0] brk_up;
    logic [AW-1:0] blk0;
    logic [AW-1:0] blk1;
    logic [AW-1:0] ustart;
    logic [IW-1:0] ix;
    logic [IW-1:0] ixn;
    logic [IW-1:0] ixp;
    logic [AW-1:0] cur_st;
    logic [AW-1:0] cur_sz;
    logic          has_cur;
    logic [AW-1:0] rsize;
    logic          left_ok;
    logic          right_ok;
    logic          st_we;

    assign amask   = (r_align >= 3'd4) ? AW'(15) : AW'(7);
    assign brk_up  = (r_brk + amask) & ~amask;
    assign blk0    = AW'(i_req_bytes) + HDR;
    assign blk1    = (((blk0 < MINB) ? MINB : blk0) + amask) & ~amask;
    assign ustart  = AW'(i_user_addr) - HDR;
    assign ix      = r_idx[IW-1:0];
    assign ixn     = IW'(r_idx + CW'(1));
    assign ixp     = IW'(r_idx - CW'(1));
    assign cur_st  = r_fst[ix];
    assign cur_sz  = r_fsz[ix];
    assign has_cur = r_idx < r_cnt;
    assign rsize   = AW'(r_rdata);
    assign left_ok  = r_left && (r_pend == r_fstart);
    assign right_ok = has_cur && (cur_st == r_fend);
    assign st_we   = (r_state == S_AWR);

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[r_base[SW+2:3]] <= DW'(r_blk);
        end
        r_rdata <= r_store[r_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_align <= 3'd3;
            r_cnt   <= '0;
            r_brk   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_align <= (i_cfg_data < 3'd3) ? 3'd3 :
                           (i_cfg_data > 3'd4) ? 3'd4 : i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op     <= i_op;
                        r_status <= ffha_pkg::ST_OK;
                        r_gaddr  <= '0;
                        r_gbytes <= '0;
                        r_top    <= 1'b0;
                        r_idx    <= '0;
                        r_left   <= 1'b0;
                        if (i_op == ffha_pkg::OP_ALLOC) begin
                            if (i_req_bytes == '0) begin
                                r_status <= ffha_pkg::ST_ZERO;
                                r_state  <= S_OUT;
                            end else begin
                                r_brk   <= (brk_up > HEAP) ? HEAP : brk_up;
                                r_blk   <= blk1;
                                r_state <= S_ASCAN;
                            end
                        end else begin
                            r_fstart <= ustart;
                            r_sidx   <= ustart[SW+2:3];
                            if (AW'(i_user_addr) < HDR || ustart[2:0] != 3'd0
                                    || ustart >= r_brk) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_FWAIT;
                            end
                        end
                    end
                end
                S_ASCAN: begin
                    if (has_cur) begin
                        if (cur_sz >= r_blk) begin
                            r_base <= cur_st;
                            if (cur_sz - r_blk >= MINB) begin
                                r_fst[ix] <= cur_st + r_blk;
                                r_fsz[ix] <= cur_sz - r_blk;
                                r_state   <= S_AWR;
                            end else begin
                                r_blk   <= cur_sz;
                                r_state <= S_SHDN;
                            end
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end else if (r_blk > HEAP - r_brk) begin
                        r_status <= ffha_pkg::ST_NOMEM;
                        r_state  <= S_OUT;
                    end else begin
                        r_base  <= r_brk;
                        r_brk   <= r_brk + r_blk;
                        r_state <= S_AWR;
                    end
                end
                S_AWR: begin
                    r_gaddr  <= 16'(r_base + HDR);
                    r_gbytes <= 17'(r_blk);
                    r_state  <= S_OUT;
                end
                S_FWAIT: begin
                    r_state <= S_FSIZE;
                end
                S_FSIZE: begin
                    r_fsize <= rsize;
                    r_fend  <= r_fstart + rsize;
                    if (rsize == '0 || rsize > r_brk - r_fstart) begin
                        r_state <= S_OUT;
                    end else if (r_fstart + rsize == r_brk) begin
                        r_brk   <= r_fstart;
                        r_top   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_FSCAN;
                    end
                end
                S_FSCAN: begin
                    if (has_cur && cur_st <= r_fstart) begin
                        r_left  <= 1'b1;
                        r_pend  <= cur_st + cur_sz;
                        r_psize <= cur_sz;
                        r_idx   <= r_idx + CW'(1);
                    end else begin
                        r_state <= S_FCHK;
                    end
                end
                S_FCHK: begin
                    r_p <= r_idx;
                    if ((r_left && r_pend > r_fstart) || (has_cur && r_fend > cur_st)) begin
                        r_state <= S_OUT;
                    end else if (left_ok && right_ok) begin
                        r_fsz[ixp] <= r_psize + r_fsize + cur_sz;
                        r_state    <= S_SHDN;
                    end else if (left_ok) begin
                        r_fsz[ixp] <= r_psize + r_fsize;
                        r_state    <= S_OUT;
                    end else if (right_ok) begin
                        r_fst[ix] <= r_fstart;
                        r_fsz[ix] <= cur_sz + r_fsize;
                        r_state   <= S_OUT;
                    end else if (r_cnt >= MAXF) begin
                        r_status <= ffha_pkg::ST_TBLFULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_idx   <= r_cnt;
                        r_state <= S_SHUP;
                    end
                end
                S_SHDN: begin
                    if (r_idx + CW'(1) < r_cnt) begin
                        r_fst[ix] <= r_fst[ixn];
                        r_fsz[ix] <= r_fsz[ixn];
                        r_idx     <= r_idx + CW'(1);
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= (r_op == ffha_pkg::OP_FREE) ? S_OUT : S_AWR;
                    end
                end
                S_SHUP: begin
                    if (r_idx > r_p) begin
                        r_fst[ix] <= r_fst[ixp];
                        r_fsz[ix] <= r_fsz[ixp];
                        r_idx     <= r_idx - CW'(1);
                    end else begin
                        r_fst[ix] <= r_fstart;
                        r_fsz[ix] <= r_fsize;
                        r_cnt     <= r_cnt + CW'(1);
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = (r_state == S_OUT);
    assign o_status       = r_status;
    assign o_grant_addr   = r_gaddr;
    assign o_grant_bytes  = r_gbytes;
    assign o_top_released = r_top;
    assign o_cfg_ready    = 1'b1;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

typedef struct {
    ffha_pkg::t_status status;
    logic [15:0]       grant_addr;
    logic [16:0]       grant_bytes;
    logic              top_released;
} t_heap_result;

class HeapScoreboard;
    int unsigned  align_reg;
    int unsigned  seg_start[ffha_pkg::MAX_FREE_DEF];
    int unsigned  seg_size[ffha_pkg::MAX_FREE_DEF];
    int unsigned  seg_count;
    int unsigned  brk;
    int unsigned  blk_sizes[int unsigned];
    t_heap_result pending_q[$];
    int           errors;

    function new();
        align_reg = 3;
        seg_count = 0;
        brk = 0;
        errors = 0;
    endfunction

    function void set_align(int unsigned v);
        align_reg = v & 7;
    endfunction

    function int unsigned align_bytes();
        int unsigned lg;
        lg = align_reg;
        if (lg < 3) lg = 3;
        if (lg > 4) lg = 4;
        return 1 << lg;
    endfunction

    // a free never reads a size entry that was never written
    function bit free_is_safe(int unsigned ua);
        int unsigned s;
        if (ua < ffha_pkg::HEADER_BYTES_DEF) return 1;
        s = ua - ffha_pkg::HEADER_BYTES_DEF;
        if ((s & 7) != 0 || s >= brk) return 1;
        return blk_sizes.exists(s >> 3);
    endfunction

    function void remove_seg(int unsigned i);
        for (int unsigned k = i; k + 1 < seg_count; k++) begin
            seg_start[k] = seg_start[k + 1];
            seg_size[k]  = seg_size[k + 1];
        end
        seg_count--;
    endfunction

    function t_heap_result predict_alloc(int unsigned req);
        t_heap_result r;
        int unsigned  a, blk, i, base;
        r = '{ffha_pkg::ST_OK, 16'd0, 17'd0, 1'b0};
        if (req == 0) begin
            r.status = ffha_pkg::ST_ZERO;
            return r;
        end
        a = align_bytes();
        brk = (brk + a - 1) & ~(a - 1);
        if (brk > ffha_pkg::HEAP_BYTES_DEF) brk = ffha_pkg::HEAP_BYTES_DEF;
        blk = req + ffha_pkg::HEADER_BYTES_DEF;
        if (blk < ffha_pkg::MIN_BLOCK_BYTES_DEF) blk = ffha_pkg::MIN_BLOCK_BYTES_DEF;
        blk = (blk + a - 1) & ~(a - 1);
        for (i = 0; i < seg_count; i++)
            if (seg_size[i] >= blk) break;
        if (i < seg_count) begin
            base = seg_start[i];
            if (seg_size[i] - blk >= ffha_pkg::MIN_BLOCK_BYTES_DEF) begin
                seg_start[i] = base + blk;
                seg_size[i]  = seg_size[i] - blk;
            end else begin
                blk = seg_size[i];
                remove_seg(i);
            end
        end else begin
            if (blk > ffha_pkg::HEAP_BYTES_DEF - brk) begin
                r.status = ffha_pkg::ST_NOMEM;
                return r;
            end
            base = brk;
            brk = brk + blk;
        end
        blk_sizes[base >> 3] = blk;
        r.grant_addr  = 16'(base + ffha_pkg::HEADER_BYTES_DEF);
        r.grant_bytes = 17'(blk);
        return r;
    endfunction

    function t_heap_result predict_free(int unsigned ua);
        t_heap_result r;
        int unsigned  s, sz, e, p;
        bit           lft, rgt;
        r = '{ffha_pkg::ST_OK, 16'd0, 17'd0, 1'b0};
        if (ua < ffha_pkg::HEADER_BYTES_DEF) return r;
        s = ua - ffha_pkg::HEADER_BYTES_DEF;
        if ((s & 7) != 0 || s >= brk) return r;
        if (!blk_sizes.exists(s >> 3)) return r;
        sz = blk_sizes[s >> 3];
        if (sz == 0 || sz > brk - s) return r;
        e = s + sz;
        if (e == brk) begin
            brk = s;
            r.top_released = 1'b1;
            return r;
        end
        for (p = 0; p < seg_count; p++)
            if (seg_start[p] > s) break;
        if (p > 0 && seg_start[p - 1] + seg_size[p - 1] > s) return r;
        if (p < seg_count && e > seg_start[p]) return r;
        lft = p > 0 && seg_start[p - 1] + seg_size[p - 1] == s;
        rgt = p < seg_count && seg_start[p] == e;
        if (lft && rgt) begin
            seg_size[p - 1] = seg_size[p - 1] + sz + seg_size[p];
            remove_seg(p);
        end else if (lft) begin
            seg_size[p - 1] = seg_size[p - 1] + sz;
        end else if (rgt) begin
            seg_start[p] = s;
            seg_size[p]  = seg_size[p] + sz;
        end else begin
            if (seg_count >= ffha_pkg::MAX_FREE_DEF) begin
                r.status = ffha_pkg::ST_TBLFULL;
                return r;
            end
            for (int unsigned k = seg_count; k > p; k--) begin
                seg_start[k] = seg_start[k - 1];
                seg_size[k]  = seg_size[k - 1];
            end
            seg_start[p] = s;
            seg_size[p]  = sz;
            seg_count++;
        end
        return r;
    endfunction

    function t_heap_result note_command(logic op, int unsigned req, int unsigned ua);
        t_heap_result r;
        if (op == ffha_pkg::OP_ALLOC) r = predict_alloc(req);
        else r = predict_free(ua);
        pending_q.push_back(r);
        return r;
    endfunction

    function void check_result(ffha_pkg::t_status st, logic [15:0] ga, logic [16:0] gb,
                               logic tr);
        t_heap_result x;
        if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat st=%0d ga=%0h gb=%0h tr=%0d",
                                       st, ga, gb, tr);
            return;
        end
        x = pending_q.pop_front();
        if (st !== x.status || ga !== x.grant_addr || gb !== x.grant_bytes ||
                tr !== x.top_released) begin
            errors++;
            if (errors <= 10)
                $display("mismatch exp st=%0d ga=%0h gb=%0h tr=%0d got st=%0d ga=%0h gb=%0h tr=%0d",
                         x.status, x.grant_addr, x.grant_bytes, x.top_released,
                         st, ga, gb, tr);
        end
    endfunction
endclass

module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_op;
    logic [16:0] i_req_bytes;
    logic [15:0] i_user_addr;
    logic        o_done;
    logic [1:0]  o_status;
    logic [15:0] o_grant_addr;
    logic [16:0] o_grant_bytes;
    logic        o_top_released;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data;

    HeapScoreboard sb;
    int unsigned   live_addrs[$];
    int unsigned   granted_addrs[$];
    int            burst_left;
    int            item_count;

    first_fit_heap_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_op(i_op), .i_req_bytes(i_req_bytes), .i_user_addr(i_user_addr),
        .o_done(o_done), .o_status(o_status), .o_grant_addr(o_grant_addr),
        .o_grant_bytes(o_grant_bytes), .o_top_released(o_top_released),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_status, o_grant_addr, o_grant_bytes, o_top_released);
    end

    task automatic send_cmd(input logic op, input int unsigned req, input int unsigned ua);
        t_heap_result r;
        int           gap;
        @(negedge i_clk);
        i_start     = 1'b1;
        i_op        = op;
        i_req_bytes = 17'(req);
        i_user_addr = 16'(ua);
        do @(posedge i_clk); while (o_busy);
        r = sb.note_command(op, req, ua);
        item_count++;
        if (op == ffha_pkg::OP_ALLOC && r.status == ffha_pkg::ST_OK) begin
            live_addrs.push_back(r.grant_addr);
            granted_addrs.push_back(r.grant_addr);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_align(input int unsigned v);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = 3'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_align(v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic free_live(input int unsigned idx);
        int unsigned a;
        a = live_addrs[idx];
        live_addrs.delete(idx);
        send_cmd(ffha_pkg::OP_FREE, 0, a);
    endtask

    task automatic rand_free();
        int unsigned a;
        int          k;
        k = $urandom_range(0, 9);
        if (k <= 6 && live_addrs.size() > 0) begin
            free_live($urandom_range(0, live_addrs.size() - 1));
        end else if (k == 7 && granted_addrs.size() > 0) begin
            send_cmd(ffha_pkg::OP_FREE, 0,
                     granted_addrs[$urandom_range(0, granted_addrs.size() - 1)]);
        end else if (k == 9) begin
            send_cmd(ffha_pkg::OP_FREE, $urandom,
                     $urandom_range(0, ffha_pkg::HEADER_BYTES_DEF - 1));
        end else begin
            a = $urandom & 16'hffff;
            if (!sb.free_is_safe(a)) a = a | 1;
            send_cmd(ffha_pkg::OP_FREE, $urandom, a);
        end
    endtask

    task automatic rand_alloc();
        int unsigned req;
        case ($urandom_range(0, 19))
            0:       req = 0;
            1:       req = $urandom & 17'h1ffff;
            2:       req = $urandom_range(1000, 20000);
            default: req = $urandom_range(1, 200);
        endcase
        if (req > 65536) req = req & 16'hffff;
        send_cmd(ffha_pkg::OP_ALLOC, req, $urandom);
    endtask

    // many small blocks, every other one freed, can overflow the free table
    task automatic fragment_heap();
        int n;
        int lo;
        n = $urandom_range(30, 40);
        repeat (n) send_cmd(ffha_pkg::OP_ALLOC, $urandom_range(1, 40), $urandom);
        lo = live_addrs.size() - n;
        if (lo < 0) lo = 0;
        for (int i = live_addrs.size() - 2; i >= lo; i -= 2)
            free_live(i);
    endtask

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        sb = new();
        item_count = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_op = ffha_pkg::OP_ALLOC;
        i_req_bytes = '0;
        i_user_addr = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        send_cmd(ffha_pkg::OP_ALLOC, 0, 0);
        send_cmd(ffha_pkg::OP_ALLOC, 65536, 16'hffff);
        send_cmd(ffha_pkg::OP_ALLOC, 1, 0);
        send_cmd(ffha_pkg::OP_ALLOC, 16, 0);
        send_cmd(ffha_pkg::OP_ALLOC, 17, 0);
        send_cmd(ffha_pkg::OP_ALLOC, 100, 0);
        send_cmd(ffha_pkg::OP_ALLOC, 40, 0);
        send_cmd(ffha_pkg::OP_FREE, 0, 0);
        send_cmd(ffha_pkg::OP_FREE, 0, 7);
        send_cmd(ffha_pkg::OP_FREE, 0, 13);
        send_cmd(ffha_pkg::OP_FREE, 0, 16'hfff8);
        free_live(1);
        free_live(2);
        free_live(1);
        send_cmd(ffha_pkg::OP_FREE, 0, granted_addrs[1]);
        send_cmd(ffha_pkg::OP_ALLOC, 30, 0);
        free_live(live_addrs.size() - 1);
        write_align(4);
        send_cmd(ffha_pkg::OP_ALLOC, 9, 0);
        send_cmd(ffha_pkg::OP_ALLOC, 65000, 0);
        write_align(7);
        send_cmd(ffha_pkg::OP_ALLOC, 3, 0);
        write_align(0);
        send_cmd(ffha_pkg::OP_ALLOC, 5, 0);
        write_align(3);

        // random
        while (item_count + live_addrs.size() < 950) begin
            case ($urandom_range(0, 59))
                0:       fragment_heap();
                1:       write_align($urandom_range(0, 7));
                2:       drain();
                default: if ($urandom_range(0, 99) < 55) rand_alloc(); else rand_free();
            endcase
        end
        while (live_addrs.size() > 0) free_live($urandom_range(0, live_addrs.size() - 1));
        write_align(5);
        send_cmd(ffha_pkg::OP_ALLOC, 1, 0);

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
